// ----- rtl/psrt_pkg.sv -----
// Shared types, constants and tables for the point scale/rotate/translate block.
// No dependencies; used by every module under rtl.
`default_nettype none
package psrt_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int TRIG_FRAC  = 16;
  localparam int TRIG_W     = 18;
  localparam int ANGLE_W    = 19;
  localparam int SCALE_W    = 32;
  localparam int SHIFT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CORDIC_W   = 34;

  localparam logic signed [ANGLE_W-1:0]  ANG_HALF_PI = 19'sd102944;
  localparam logic signed [ANGLE_W-1:0]  ANG_PI      = 19'sd205887;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [TRIG_W-1:0]   TRIG_ONE    = 18'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE   = 3'd0,
    CFG_ANGLE_X = 3'd1,
    CFG_ANGLE_Y = 3'd2,
    CFG_ANGLE_Z = 3'd3,
    CFG_SHIFT_X = 3'd4,
    CFG_SHIFT_Y = 3'd5,
    CFG_SHIFT_Z = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TRIG_LOAD,
    TRIG_ITER,
    TRIG_STORE,
    TRIG_DONE
  } trig_state_t;

  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef struct packed {
    trig_t cos_x;
    trig_t sin_x;
    trig_t cos_y;
    trig_t sin_y;
    trig_t cos_z;
    trig_t sin_z;
  } trig_set_t;

  // arctangent of 2^-i, Q2.30, truncated
  function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CORDIC_W-1:0] v;
    unique case (idx)
      5'd0:    v = 34'sd843314856;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043836;
      5'd3:    v = 34'sd133525158;
      5'd4:    v = 34'sd67021686;
      5'd5:    v = 34'sd33543515;
      5'd6:    v = 34'sd16775850;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194282;
      5'd9:    v = 34'sd2097149;
      5'd10:   v = 34'sd1048575;
      5'd11:   v = 34'sd524287;
      5'd12:   v = 34'sd262143;
      5'd13:   v = 34'sd131071;
      5'd14:   v = 34'sd65535;
      5'd15:   v = 34'sd32767;
      5'd16:   v = 34'sd16383;
      5'd17:   v = 34'sd8191;
      5'd18:   v = 34'sd4095;
      5'd19:   v = 34'sd2047;
      5'd20:   v = 34'sd1023;
      5'd21:   v = 34'sd511;
      5'd22:   v = 34'sd255;
      5'd23:   v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/psrt_trig.sv -----
// Iterative CORDIC that fills the cosine/sine cache for the three angles.
// Depends on psrt_pkg.
`default_nettype none
module psrt_trig #(
  parameter int CORDIC_STEPS = psrt_pkg::CORDIC_STEPS
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    restart,
  input  wire logic signed [psrt_pkg::ANGLE_W-1:0] angle_x,
  input  wire logic signed [psrt_pkg::ANGLE_W-1:0] angle_y,
  input  wire logic signed [psrt_pkg::ANGLE_W-1:0] angle_z,
  output psrt_pkg::trig_set_t                    trig,
  output logic                                   trig_ok
);

  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int CW = psrt_pkg::CORDIC_W;

  psrt_pkg::trig_state_t state_r, state_nxt;
  logic [1:0]    axis_r, axis_nxt;
  logic [SW-1:0] step_r, step_nxt;

  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic                 flip_r;
  psrt_pkg::trig_set_t  cache_r;

  logic signed [psrt_pkg::ANGLE_W-1:0] ang;
  logic signed [psrt_pkg::ANGLE_W:0]   ang_fold;
  logic                                fold;
  logic signed [CW-1:0] dx, dy, at;
  logic signed [CW-1:0] rx, ry, nx, ny;
  psrt_pkg::trig_t      cv, sv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psrt_pkg::TRIG_LOAD;
      axis_r  <= 2'd0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    step_nxt  = step_r;
    unique case (state_r)
      psrt_pkg::TRIG_LOAD: begin
        state_nxt = psrt_pkg::TRIG_ITER;
        step_nxt  = '0;
      end
      psrt_pkg::TRIG_ITER: begin
        if (step_r == SW'(CORDIC_STEPS - 1)) begin
          state_nxt = psrt_pkg::TRIG_STORE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      psrt_pkg::TRIG_STORE: begin
        if (axis_r == 2'd2) begin
          state_nxt = psrt_pkg::TRIG_DONE;
        end else begin
          state_nxt = psrt_pkg::TRIG_LOAD;
          axis_nxt  = axis_r + 2'd1;
        end
      end
      psrt_pkg::TRIG_DONE: state_nxt = psrt_pkg::TRIG_DONE;
      default:             state_nxt = psrt_pkg::TRIG_LOAD;
    endcase
    if (restart) begin
      state_nxt = psrt_pkg::TRIG_LOAD;
      axis_nxt  = 2'd0;
    end
  end

  always_comb begin
    unique case (axis_r)
      2'd0:    ang = angle_x;
      2'd1:    ang = angle_y;
      default: ang = angle_z;
    endcase
    fold = 1'b1;
    if (ang > psrt_pkg::ANG_HALF_PI) begin
      ang_fold = ang - psrt_pkg::ANG_PI;
    end else if (ang < -psrt_pkg::ANG_HALF_PI) begin
      ang_fold = ang + psrt_pkg::ANG_PI;
    end else begin
      ang_fold = ang;
      fold     = 1'b0;
    end
  end

  assign dx = cy_r >>> step_r;
  assign dy = cx_r >>> step_r;
  assign at = psrt_pkg::atan_q30(5'(step_r));

  // Q2.30 to Q1.16, round half up
  assign rx = (cx_r + CW'(8192)) >>> 14;
  assign ry = (cy_r + CW'(8192)) >>> 14;
  assign nx = flip_r ? -rx : rx;
  assign ny = flip_r ? -ry : ry;

  always_comb begin
    if (nx > CW'(psrt_pkg::TRIG_ONE)) begin
      cv = psrt_pkg::TRIG_ONE;
    end else if (nx < -CW'(psrt_pkg::TRIG_ONE)) begin
      cv = -psrt_pkg::TRIG_ONE;
    end else begin
      cv = nx[psrt_pkg::TRIG_W-1:0];
    end
    if (ny > CW'(psrt_pkg::TRIG_ONE)) begin
      sv = psrt_pkg::TRIG_ONE;
    end else if (ny < -CW'(psrt_pkg::TRIG_ONE)) begin
      sv = -psrt_pkg::TRIG_ONE;
    end else begin
      sv = ny[psrt_pkg::TRIG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_r <= '0;
    end else begin
      unique case (state_r)
        psrt_pkg::TRIG_LOAD: begin
          cx_r   <= psrt_pkg::CORDIC_GAIN;
          cy_r   <= '0;
          cz_r   <= CW'(ang_fold) <<< 14;
          flip_r <= fold;
        end
        psrt_pkg::TRIG_ITER: begin
          if (!cz_r[CW-1]) begin
            cx_r <= cx_r - dx;
            cy_r <= cy_r + dy;
            cz_r <= cz_r - at;
          end else begin
            cx_r <= cx_r + dx;
            cy_r <= cy_r - dy;
            cz_r <= cz_r + at;
          end
        end
        psrt_pkg::TRIG_STORE: begin
          unique case (axis_r)
            2'd0: begin
              cache_r.cos_x <= cv;
              cache_r.sin_x <= sv;
            end
            2'd1: begin
              cache_r.cos_y <= cv;
              cache_r.sin_y <= sv;
            end
            default: begin
              cache_r.cos_z <= cv;
              cache_r.sin_z <= sv;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign trig    = cache_r;
  assign trig_ok = (state_r == psrt_pkg::TRIG_DONE);

endmodule
`default_nettype wire

// ----- rtl/psrt_scale.sv -----
// Two-stage uniform scale: products, then rounding and saturation.
// Depends on psrt_pkg.
`default_nettype none
module psrt_scale #(
  parameter int COORD_WIDTH = psrt_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = psrt_pkg::FRAC_BITS
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              s_valid,
  output logic                             s_ready,
  input  wire  [2:0][COORD_WIDTH-1:0]      s_pt,
  input  wire                              s_last,
  input  wire  [psrt_pkg::SCALE_W-1:0]     scale,
  output logic                             m_valid,
  input  wire                              m_ready,
  output logic [2:0][COORD_WIDTH-1:0]      m_pt,
  output logic                             m_last
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = W + psrt_pkg::SCALE_W + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] MAXV = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW-1:0] MINV = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};

  logic signed [PW-1:0] prod_r [3];
  logic                 va_r, last_a_r;
  logic                 vb_r, last_b_r;
  logic [2:0][W-1:0]    pt_b_r;
  logic                 en_a, en_b;
  logic signed [PW-1:0] rnd [3];
  logic [2:0][W-1:0]    pt_nxt;

  assign en_b    = !vb_r || m_ready;
  assign en_a    = !va_r || en_b;
  assign s_ready = en_a;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (prod_r[i] + (prod_r[i][PW-1] ? HALF - PW'(1) : HALF)) >>> FRAC_BITS;
      if (rnd[i] > MAXV) begin
        pt_nxt[i] = MAXV[W-1:0];
      end else if (rnd[i] < MINV) begin
        pt_nxt[i] = MINV[W-1:0];
      end else begin
        pt_nxt[i] = rnd[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= s_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= $signed(s_pt[i]) * $signed({1'b0, scale});
      end
      last_a_r <= s_last;
    end
    if (en_b) begin
      pt_b_r   <= pt_nxt;
      last_b_r <= last_a_r;
    end
  end

  assign m_valid = vb_r;
  assign m_pt    = pt_b_r;
  assign m_last  = last_b_r;

endmodule
`default_nettype wire

// ----- rtl/psrt_rot.sv -----
// Two-stage plane rotation (transposed matrix): a' = a*c + b*s, b' = b*c - a*s.
// Depends on psrt_pkg.
`default_nettype none
module psrt_rot #(
  parameter int COORD_WIDTH = psrt_pkg::COORD_WIDTH
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          s_valid,
  output logic                         s_ready,
  input  wire  [COORD_WIDTH-1:0]       s_a,
  input  wire  [COORD_WIDTH-1:0]       s_b,
  input  wire  [COORD_WIDTH-1:0]       s_p,
  input  wire                          s_last,
  input  psrt_pkg::trig_t              cos_v,
  input  psrt_pkg::trig_t              sin_v,
  output logic                         m_valid,
  input  wire                          m_ready,
  output logic [COORD_WIDTH-1:0]       m_a,
  output logic [COORD_WIDTH-1:0]       m_b,
  output logic [COORD_WIDTH-1:0]       m_p,
  output logic                         m_last
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = W + psrt_pkg::TRIG_W;
  localparam int SW = PW + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (psrt_pkg::TRIG_FRAC - 1);
  localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  // 0: a*c, 1: b*s, 2: b*c, 3: a*s
  logic signed [PW-1:0] prod_r [4];
  logic signed [PW-1:0] rnd [4];
  logic [W-1:0]         p_a_r, p_b_r;
  logic                 va_r, vb_r, last_a_r, last_b_r;
  logic [W-1:0]         a_r, b_r;
  logic signed [SW-1:0] sum_a, sum_b;
  logic [W-1:0]         a_nxt, b_nxt;
  logic                 en_a, en_b;

  assign en_b    = !vb_r || m_ready;
  assign en_a    = !va_r || en_b;
  assign s_ready = en_a;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rnd[i] = (prod_r[i] + (prod_r[i][PW-1] ? HALF - PW'(1) : HALF))
               >>> psrt_pkg::TRIG_FRAC;
    end
    sum_a = SW'(rnd[0]) + SW'(rnd[1]);
    sum_b = SW'(rnd[2]) - SW'(rnd[3]);
    if (sum_a > MAXV) a_nxt = MAXV[W-1:0];
    else if (sum_a < MINV) a_nxt = MINV[W-1:0];
    else a_nxt = sum_a[W-1:0];
    if (sum_b > MAXV) b_nxt = MAXV[W-1:0];
    else if (sum_b < MINV) b_nxt = MINV[W-1:0];
    else b_nxt = sum_b[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= s_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      prod_r[0] <= $signed(s_a) * cos_v;
      prod_r[1] <= $signed(s_b) * sin_v;
      prod_r[2] <= $signed(s_b) * cos_v;
      prod_r[3] <= $signed(s_a) * sin_v;
      p_a_r     <= s_p;
      last_a_r  <= s_last;
    end
    if (en_b) begin
      a_r      <= a_nxt;
      b_r      <= b_nxt;
      p_b_r    <= p_a_r;
      last_b_r <= last_a_r;
    end
  end

  assign m_valid = vb_r;
  assign m_a     = a_r;
  assign m_b     = b_r;
  assign m_p     = p_b_r;
  assign m_last  = last_b_r;

endmodule
`default_nettype wire

// ----- rtl/point_scale_rotate_translate.sv -----
// Top level: configuration registers, trig cache, scale/rotate pipeline, translate.
// Depends on psrt_pkg, psrt_trig, psrt_scale and psrt_rot.
//
// Use:
//   in_*   : one point per request; tdata = {z, y, x}, x lowest, tlast = last point.
//   out_*  : one transformed point per request; tdata = {z, y, x}, tuser = behind
//            screen (z below zero), tlast copies the input mark.
//   cfg_*  : register writes (index, data); always ready; write only while idle.
// Pipeline: scale, three rotations, translate output register. Throughput
// one point per cycle while the receiver is ready and the trig cache is
// valid; every stage has its own valid and stalls only when full, so a
// stalled receiver back-pressures stage by stage and nothing is lost.
// After reset and after any angle write the CORDIC refills the cosine/sine
// cache; in_tready stays low until it is done. Reset loads scale 1.0, zero
// angles and zero shifts.
`default_nettype none
module point_scale_rotate_translate #(
  parameter int COORD_WIDTH  = psrt_pkg::COORD_WIDTH,
  parameter int FRAC_BITS    = psrt_pkg::FRAC_BITS,
  parameter int CORDIC_STEPS = psrt_pkg::CORDIC_STEPS,
  localparam int DW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [DW-1:0]                      in_tdata,  // point_x, point_y, point_z
  input  wire                                in_tlast,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [DW-1:0]                      out_tdata, // out_x, out_y, out_z
  output logic                               out_tuser, // behind_screen
  output logic                               out_tlast,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [psrt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [psrt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int W  = COORD_WIDTH;
  localparam int TW = W + psrt_pkg::SHIFT_W + 1;
  localparam logic signed [TW-1:0] MAXV = {{(TW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [TW-1:0] MINV = {{(TW-W+1){1'b1}}, {(W-1){1'b0}}};

  logic [psrt_pkg::SCALE_W-1:0]        scale_r;
  logic signed [psrt_pkg::ANGLE_W-1:0] ang_x_r, ang_y_r, ang_z_r;
  logic signed [psrt_pkg::SHIFT_W-1:0] shift_x_r, shift_y_r, shift_z_r;
  logic                                cfg_wr, angle_wr;

  psrt_pkg::trig_set_t trig;
  logic                trig_ok;

  logic [2:0][W-1:0] in_pt, sc_pt;
  logic              sc_s_ready, sc_valid, sc_last, sc_ready;
  logic [W-1:0]      rx_a, rx_b, rx_p;
  logic              rx_valid, rx_last, rx_ready;
  logic [W-1:0]      ry_a, ry_b, ry_p;
  logic              ry_valid, ry_last, ry_ready;
  logic [W-1:0]      rz_a, rz_b, rz_p;
  logic              rz_valid, rz_last;

  logic                 ov_r, olast_r, obehind_r;
  logic [2:0][W-1:0]    opt_r;
  logic [2:0][W-1:0]    opt_nxt;
  logic signed [TW-1:0] tsum [3];
  logic [2:0][W-1:0]    tin;
  logic [2:0][psrt_pkg::SHIFT_W-1:0] tsh;
  logic                 en_o;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign angle_wr  = cfg_wr && (cfg_index == psrt_pkg::CFG_ANGLE_X ||
                                cfg_index == psrt_pkg::CFG_ANGLE_Y ||
                                cfg_index == psrt_pkg::CFG_ANGLE_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= 32'd65536;
      ang_x_r   <= '0;
      ang_y_r   <= '0;
      ang_z_r   <= '0;
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        psrt_pkg::CFG_SCALE:   scale_r   <= cfg_data;
        psrt_pkg::CFG_ANGLE_X: ang_x_r   <= cfg_data[psrt_pkg::ANGLE_W-1:0];
        psrt_pkg::CFG_ANGLE_Y: ang_y_r   <= cfg_data[psrt_pkg::ANGLE_W-1:0];
        psrt_pkg::CFG_ANGLE_Z: ang_z_r   <= cfg_data[psrt_pkg::ANGLE_W-1:0];
        psrt_pkg::CFG_SHIFT_X: shift_x_r <= cfg_data;
        psrt_pkg::CFG_SHIFT_Y: shift_y_r <= cfg_data;
        psrt_pkg::CFG_SHIFT_Z: shift_z_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  psrt_trig #(.CORDIC_STEPS(CORDIC_STEPS)) u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (angle_wr),
    .angle_x (ang_x_r),
    .angle_y (ang_y_r),
    .angle_z (ang_z_r),
    .trig    (trig),
    .trig_ok (trig_ok)
  );

  assign in_pt[0]  = in_tdata[W-1:0];
  assign in_pt[1]  = in_tdata[2*W-1:W];
  assign in_pt[2]  = in_tdata[3*W-1:2*W];
  assign in_tready = sc_s_ready && trig_ok;

  psrt_scale #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid && trig_ok),
    .s_ready (sc_s_ready),
    .s_pt    (in_pt),
    .s_last  (in_tlast),
    .scale   (scale_r),
    .m_valid (sc_valid),
    .m_ready (sc_ready),
    .m_pt    (sc_pt),
    .m_last  (sc_last)
  );

  // about x: a = y, b = z, p = x
  psrt_rot #(.COORD_WIDTH(W)) u_rot_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (sc_valid),
    .s_ready (sc_ready),
    .s_a     (sc_pt[1]),
    .s_b     (sc_pt[2]),
    .s_p     (sc_pt[0]),
    .s_last  (sc_last),
    .cos_v   (trig.cos_x),
    .sin_v   (trig.sin_x),
    .m_valid (rx_valid),
    .m_ready (rx_ready),
    .m_a     (rx_a),
    .m_b     (rx_b),
    .m_p     (rx_p),
    .m_last  (rx_last)
  );

  // about y: a = z, b = x, p = y
  psrt_rot #(.COORD_WIDTH(W)) u_rot_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (rx_valid),
    .s_ready (rx_ready),
    .s_a     (rx_b),
    .s_b     (rx_p),
    .s_p     (rx_a),
    .s_last  (rx_last),
    .cos_v   (trig.cos_y),
    .sin_v   (trig.sin_y),
    .m_valid (ry_valid),
    .m_ready (ry_ready),
    .m_a     (ry_a),
    .m_b     (ry_b),
    .m_p     (ry_p),
    .m_last  (ry_last)
  );

  // about z: a = x, b = y, p = z
  psrt_rot #(.COORD_WIDTH(W)) u_rot_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (ry_valid),
    .s_ready (ry_ready),
    .s_a     (ry_b),
    .s_b     (ry_p),
    .s_p     (ry_a),
    .s_last  (ry_last),
    .cos_v   (trig.cos_z),
    .sin_v   (trig.sin_z),
    .m_valid (rz_valid),
    .m_ready (en_o),
    .m_a     (rz_a),
    .m_b     (rz_b),
    .m_p     (rz_p),
    .m_last  (rz_last)
  );

  assign en_o = !ov_r || out_tready;

  assign tin[0] = rz_a;
  assign tin[1] = rz_b;
  assign tin[2] = rz_p;
  assign tsh[0] = shift_x_r;
  assign tsh[1] = shift_y_r;
  assign tsh[2] = shift_z_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i] = TW'($signed(tin[i])) + TW'($signed(tsh[i]));
      if (tsum[i] > MAXV) opt_nxt[i] = MAXV[W-1:0];
      else if (tsum[i] < MINV) opt_nxt[i] = MINV[W-1:0];
      else opt_nxt[i] = tsum[i][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en_o) begin
      ov_r <= rz_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      opt_r     <= opt_nxt;
      obehind_r <= opt_nxt[2][W-1];
      olast_r   <= rz_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = DW'(opt_r);
  assign out_tuser  = obehind_r;
  assign out_tlast  = olast_r;

`ifndef NO_ASSERTIONS
  a_no_accept_stale_trig: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> trig_ok)
    else $error("point accepted while trig cache not ready");

  a_angle_write_invalidates: assert property (@(posedge clk) disable iff (!rst_n)
    angle_wr |=> !trig_ok)
    else $error("trig cache still marked valid after angle write");

  a_trig_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    trig_ok |-> trig.cos_x <= psrt_pkg::TRIG_ONE && trig.cos_x >= -psrt_pkg::TRIG_ONE
             && trig.sin_z <= psrt_pkg::TRIG_ONE && trig.sin_z >= -psrt_pkg::TRIG_ONE)
    else $error("cached trig value out of range");

  a_behind_matches_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == opt_r[2][W-1])
    else $error("behind-screen flag disagrees with z");
`endif

endmodule
`default_nettype wire
